/* design/cmah_pkg.sv */
// ----------------------------------------------------------------------------
// cmah_pkg
// Shared types and constants of the calibrated moving average height block.
// ----------------------------------------------------------------------------
package cmah_pkg;

    localparam int DEF_WINDOW      = 100;
    localparam int DEF_SAMPLE_BITS = 10;

    localparam int MV_W      = 12;
    localparam int HT_W      = 20;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int PERCENT   = 100;

    localparam logic [CFG_W-1:0] FULL_SCALE_RST = 12'd3000;
    localparam logic [CFG_W-1:0] TOP_RST        = 12'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FULL_SCALE = 2'd0,
        REG_TOP        = 2'd1
    } t_reg_idx;

    typedef enum logic [1:0] {
        SEL_MEAN = 2'd0,
        SEL_MV   = 2'd1,
        SEL_HT   = 2'd2
    } t_div_sel;

    typedef struct packed {
        logic     load;
        logic     acc;
        logic     div_go;
        t_div_sel div_sel;
        logic     mul;
        logic     scale;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

/* design/calibrated_moving_average_height.sv */
// ----------------------------------------------------------------------------
// calibrated_moving_average_height
// Boxcar mean of ADC samples in millivolts, reference capture at first full
// window, and signed height percentage against the top level.
//
//   channel   direction  handshake              word
//   input     in         i_valid / o_stall      i_sample
//   output    out        o_valid / i_stall      o_mean_mv, o_reference_mv,
//                                               o_height_percent, o_height_valid
//   config    in         i_cfg_we               i_cfg_index, i_cfg_data
//
// Each word passes three times through the shared two-bit-per-cycle divider.
// Synchronous active-low reset; the sample ring needs no clearing pass.
// A new word is taken while the previous result waits in the output register;
// a stalled output holds the sequencer only at its final load step.
// ----------------------------------------------------------------------------
module calibrated_moving_average_height import cmah_pkg::*; #(
    parameter int WINDOW      = DEF_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [MV_W-1:0]        o_mean_mv,
    output logic [MV_W-1:0]        o_reference_mv,
    output logic signed [HT_W-1:0] o_height_percent,
    output logic                   o_height_valid,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    cmah_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    cmah_datapath #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_sample         (i_sample),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_mean_mv        (o_mean_mv),
        .o_reference_mv   (o_reference_mv),
        .o_height_percent (o_height_percent),
        .o_height_valid   (o_height_valid)
    );

endmodule

/* design/cmah_div.sv */
// ----------------------------------------------------------------------------
// cmah_div
// Restoring unsigned divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module cmah_div #(
    parameter int DIV_W = 22,
    parameter int DVS_W = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic [DIV_W-1:0] o_quotient,
    output logic             o_done
);

    localparam int ITER  = DIV_W / 2;
    localparam int CNT_W = $clog2(ITER + 1);

    logic [DVS_W:0]   r_rem, n_rem;
    logic [DIV_W-1:0] r_quo, n_quo;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < 2; k++) begin
            n_rem = {n_rem[DVS_W-1:0], n_quo[DIV_W-1]};
            n_quo = {n_quo[DIV_W-2:0], 1'b0};
            if (n_rem >= {1'b0, r_dvs}) begin
                n_rem    = n_rem - {1'b0, r_dvs};
                n_quo[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ITER);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

/* design/cmah_datapath.sv */
// ----------------------------------------------------------------------------
// cmah_datapath
// Sample ring, running sum, config registers, scaling and output register.
// ----------------------------------------------------------------------------
module cmah_datapath import cmah_pkg::*; #(
    parameter int WINDOW      = DEF_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic                   i_stall,
    output logic                   o_valid,
    output logic [MV_W-1:0]        o_mean_mv,
    output logic [MV_W-1:0]        o_reference_mv,
    output logic signed [HT_W-1:0] o_height_percent,
    output logic                   o_height_valid
);

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
    localparam int PROD_W = SAMPLE_BITS + CFG_W;
    localparam int RAW_W  = (SUM_W > PROD_W) ? ((SUM_W > HT_W - 1) ? SUM_W : HT_W - 1)
                                             : ((PROD_W > HT_W - 1) ? PROD_W : HT_W - 1);
    localparam int DIV_W  = ((RAW_W + 1) / 2) * 2;
    localparam int DVS_A  = (FILL_W > SAMPLE_BITS) ? FILL_W : SAMPLE_BITS;
    localparam int DVS_W  = (DVS_A > MV_W) ? DVS_A : MV_W;

    localparam logic [DVS_W-1:0] WIN_DVS = DVS_W'(WINDOW);
    localparam logic [DVS_W-1:0] ADC_MAX = DVS_W'((1 << SAMPLE_BITS) - 1);
    localparam logic signed [HT_W-1:0] PCT = HT_W'(PERCENT);

    logic [SAMPLE_BITS-1:0] r_mem [WINDOW];
    logic [SAMPLE_BITS-1:0] r_rd;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [SLOT_W-1:0]      r_slot;
    logic [FILL_W-1:0]      r_fill;
    logic [SUM_W-1:0]       r_sum;
    logic [CFG_W-1:0]       r_full_scale;
    logic [CFG_W-1:0]       r_top;
    logic [PROD_W-1:0]      r_prod;
    logic [MV_W-1:0]        r_mv;
    logic [MV_W-1:0]        r_ref;
    logic                   r_taken;
    logic [HT_W-1:0]        r_num_mag;
    logic [MV_W-1:0]        r_den_mag;
    logic                   r_neg;
    logic                   r_hvalid;
    logic                   r_out_valid;
    logic [MV_W-1:0]        r_out_mv;
    logic [MV_W-1:0]        r_out_ref;
    logic [HT_W-1:0]        r_out_ht;
    logic                   r_out_hv;

    logic [DIV_W-1:0]       div_dividend;
    logic [DVS_W-1:0]       div_divisor;
    logic [DIV_W-1:0]       div_quo;
    logic                   div_done;

    logic [SAMPLE_BITS-1:0] old_sample;
    logic                   full;
    logic [MV_W-1:0]        mv;
    logic                   capture;
    logic [MV_W-1:0]        n_ref;
    logic signed [MV_W:0]   diff;
    logic signed [MV_W:0]   den;
    logic signed [HT_W-1:0] num;
    logic [HT_W-1:0]        ht_mag;

    always_comb begin
        case (i_cmd.div_sel)
            SEL_MEAN: begin
                div_dividend = DIV_W'(r_sum);
                div_divisor  = WIN_DVS;
            end
            SEL_MV: begin
                div_dividend = DIV_W'(r_prod);
                div_divisor  = ADC_MAX;
            end
            SEL_HT: begin
                div_dividend = DIV_W'(r_num_mag);
                div_divisor  = DVS_W'(r_den_mag);
            end
            default: begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    cmah_div #(
        .DIV_W (DIV_W),
        .DVS_W (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_go),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (div_quo),
        .o_done     (div_done)
    );

    assign full       = (r_fill == FILL_W'(WINDOW));
    assign old_sample = full ? r_rd : '0;
    assign mv         = div_quo[MV_W-1:0];
    assign capture    = full && !r_taken;
    assign n_ref      = capture ? mv : r_ref;
    assign diff       = $signed({1'b0, mv}) - $signed({1'b0, n_ref});
    assign den        = $signed({1'b0, r_top}) - $signed({1'b0, n_ref});
    assign num        = HT_W'(diff) * PCT;
    assign ht_mag     = div_quo[HT_W-1:0];

    // ring memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd <= r_mem[r_slot];
        end
        if (i_cmd.acc) begin
            r_mem[r_slot] <= r_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot       <= '0;
            r_fill       <= '0;
            r_sum        <= '0;
            r_ref        <= '0;
            r_taken      <= 1'b0;
            r_full_scale <= FULL_SCALE_RST;
            r_top        <= TOP_RST;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_FULL_SCALE: r_full_scale <= i_cfg_data;
                    REG_TOP:        r_top        <= i_cfg_data;
                    default:        ;
                endcase
            end
            if (i_cmd.acc) begin
                r_sum  <= r_sum - SUM_W'(old_sample) + SUM_W'(r_sample);
                r_slot <= (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + SLOT_W'(1);
                if (!full) begin
                    r_fill <= r_fill + FILL_W'(1);
                end
            end
            if (i_cmd.scale) begin
                r_ref <= n_ref;
                if (capture) begin
                    r_taken <= 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(div_quo[SAMPLE_BITS-1:0]) * PROD_W'(r_full_scale);
        end
        if (i_cmd.scale) begin
            r_mv      <= mv;
            r_num_mag <= num[HT_W-1] ? HT_W'(-num) : HT_W'(num);
            r_den_mag <= den[MV_W] ? MV_W'(-den) : den[MV_W-1:0];
            r_neg     <= num[HT_W-1] ^ den[MV_W];
            r_hvalid  <= (capture || r_taken) && (n_ref != '0) && (r_top != n_ref);
        end
        if (i_cmd.out_load) begin
            r_out_mv  <= r_mv;
            r_out_ref <= r_ref;
            r_out_hv  <= r_hvalid;
            r_out_ht  <= !r_hvalid ? '0 : (r_neg ? -ht_mag : ht_mag);
        end
    end

    assign o_stat.div_done = div_done;
    assign o_stat.out_free = !r_out_valid || !i_stall;

    assign o_valid          = r_out_valid;
    assign o_mean_mv        = r_out_mv;
    assign o_reference_mv   = r_out_ref;
    assign o_height_percent = $signed(r_out_ht);
    assign o_height_valid   = r_out_hv;

endmodule

/* design/cmah_ctrl.sv */
// ----------------------------------------------------------------------------
// cmah_ctrl
// Sequencer: ring update, three divider passes, output load.
// ----------------------------------------------------------------------------
module cmah_ctrl import cmah_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [10:0] {
        ST_IDLE    = 11'b000_0000_0001,
        ST_SUM     = 11'b000_0000_0010,
        ST_DIV1_GO = 11'b000_0000_0100,
        ST_DIV1    = 11'b000_0000_1000,
        ST_MUL     = 11'b000_0001_0000,
        ST_DIV2_GO = 11'b000_0010_0000,
        ST_DIV2    = 11'b000_0100_0000,
        ST_SCALE   = 11'b000_1000_0000,
        ST_DIV3_GO = 11'b001_0000_0000,
        ST_DIV3    = 11'b010_0000_0000,
        ST_OUT     = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.div_sel  = SEL_MEAN;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SUM;
                end
            end
            ST_SUM: begin
                o_cmd.acc = 1'b1;
                n_state   = ST_DIV1_GO;
            end
            ST_DIV1_GO: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_sel = SEL_MEAN;
                n_state       = ST_DIV1;
            end
            ST_DIV1: begin
                if (i_stat.div_done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_DIV2_GO;
            end
            ST_DIV2_GO: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_sel = SEL_MV;
                n_state       = ST_DIV2;
            end
            ST_DIV2: begin
                if (i_stat.div_done) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_DIV3_GO;
            end
            ST_DIV3_GO: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_sel = SEL_HT;
                n_state       = ST_DIV3;
            end
            ST_DIV3: begin
                if (i_stat.div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != ST_IDLE);

endmodule
